>>> rtl/sps_pkg.sv
// shared types, codes and coil tables for the stepper phase sequencer
// no dependencies; used by the channel interfaces and the top level
package sps_pkg;

  localparam int STEP_W = 31;
  localparam logic [STEP_W-1:0] MAG_MAX = {STEP_W{1'b1}};
  localparam int PERIOD_W = 16;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd500;

  // config register index, taken from paddr[2]
  localparam logic REG_MODE   = 1'b0;
  localparam logic REG_PERIOD = 1'b1;

  typedef enum logic [1:0] {
    CMD_TICK = 2'd0,
    CMD_MOVE = 2'd1,
    CMD_REVS = 2'd2
  } cmd_code_t;

  // wave drive: one coil at a time
  function automatic logic [3:0] wave_pattern(input logic [1:0] idx);
    logic [3:0] pat;
    case (idx)
      2'd0: pat = 4'h1;
      2'd1: pat = 4'h2;
      2'd2: pat = 4'h4;
      default: pat = 4'h8;
    endcase
    return pat;
  endfunction

  // half step: alternate single and paired coils
  function automatic logic [3:0] half_pattern(input logic [2:0] idx);
    logic [3:0] pat;
    case (idx)
      3'd0: pat = 4'h1;
      3'd1: pat = 4'h3;
      3'd2: pat = 4'h2;
      3'd3: pat = 4'h6;
      3'd4: pat = 4'h4;
      3'd5: pat = 4'hC;
      3'd6: pat = 4'h8;
      default: pat = 4'h9;
    endcase
    return pat;
  endfunction

endpackage

>>> rtl/sps_cmd_if.sv
// command channel: valid/ready plus the command word fields
// imports sps_pkg; the field widths are written out as literals
interface sps_cmd_if;
  import sps_pkg::*;

  logic                valid;
  logic                ready;
  logic [1:0]          command;
  logic signed [31:0]  step_count;
  logic signed [15:0]  revolutions;

  modport source (output valid, command, step_count, revolutions, input ready);
  modport sink (input valid, command, step_count, revolutions, output ready);
endinterface

>>> rtl/sps_res_if.sv
// result channel: valid/ready plus the coil status word fields
// depends on sps_pkg for field widths
interface sps_res_if;
  import sps_pkg::*;

  logic              valid;
  logic              ready;
  logic [3:0]        coil_pattern;
  logic              busy_res;
  logic [STEP_W-1:0] steps_done;

  modport source (output valid, coil_pattern, busy_res, steps_done, input ready);
  modport sink (input valid, coil_pattern, busy_res, steps_done, output ready);
endinterface

>>> rtl/stepper_phase_sequencer.sv
// stepper phase sequencer top level: move state, period timer, coil tables
// depends on sps_pkg, sps_cmd_if and sps_res_if
//
//   channel  | dir | handshake           | word
//   ---------+-----+---------------------+---------------------------------------
//   cmd      | in  | valid/ready         | command, step_count, revolutions
//   res      | out | valid/ready         | coil_pattern, busy_res, steps_done
//   apb      | in  | psel/penable/pready | half_step_mode @0, step_period_us @4
//
// every command word is handled at its accepting edge: the move state and the result
// register update together there, so a result is valid in the cycle after its command
// is accepted, and a new word can be taken every cycle while res.ready takes each result
// the single result register is the only buffer; cmd.ready drops only while
// that register holds a word that res.ready does not take
// rst is synchronous and clears move state, the timer and the result valid
module stepper_phase_sequencer #(
  parameter int STEPS_PER_TURN_WAVE = 2048,
  parameter int STEPS_PER_TURN_HALF = 4096
) (
  input  logic        clk,
  input  logic        rst,
  sps_cmd_if.sink     cmd,
  sps_res_if.source   res,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import sps_pkg::*;

  // width of the steps-per-turn constant and the revolutions product
  localparam int PER_MAX = (STEPS_PER_TURN_WAVE > STEPS_PER_TURN_HALF) ?
                           STEPS_PER_TURN_WAVE : STEPS_PER_TURN_HALF;
  localparam int PER_W   = $clog2(PER_MAX + 1);
  localparam int PROD_W  = 16 + PER_W;

  // configuration registers
  logic                half_step_mode;
  logic [PERIOD_W-1:0] step_period_us;

  // move state
  logic [STEP_W-1:0]   steps_issued, steps_issued_next;
  logic [STEP_W-1:0]   target_steps, target_steps_next;
  logic                forward, forward_next;
  logic                armed, armed_next;
  logic [PERIOD_W-1:0] period_count, period_count_next;
  logic [3:0]          coil_register, coil_register_next;

  // result register
  logic                res_valid;
  logic [3:0]          res_coil;
  logic                res_busy;
  logic [STEP_W-1:0]   res_steps;

  logic cmd_fire;
  logic cfg_write;

  // ---------------------------------------------------------------------------
  // apb config port, register picked by paddr[2]
  // ---------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_step_mode <= 1'b0;
      step_period_us <= PERIOD_RESET;
    end else if (cfg_write) begin
      case (paddr[2])
        REG_MODE:   half_step_mode <= pwdata[0];
        REG_PERIOD: step_period_us <= pwdata[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_MODE:   prdata = {31'd0, half_step_mode};
      REG_PERIOD: prdata = {{(32-PERIOD_W){1'b0}}, step_period_us};
      default:    prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // handshake: take a word whenever the result register is free or draining
  // ---------------------------------------------------------------------------
  assign cmd.ready = !res_valid || res.ready;
  assign cmd_fire  = cmd.valid && cmd.ready;

  // ---------------------------------------------------------------------------
  // move magnitudes
  // ---------------------------------------------------------------------------
  logic              move_neg;
  logic [31:0]       move_abs;
  logic [STEP_W-1:0] move_mag;

  // two's complement magnitude; the most negative count lands on bit 31
  // and saturates with everything else that does not fit
  assign move_neg = cmd.step_count[31];
  assign move_abs = move_neg ? (~cmd.step_count + 32'd1) : cmd.step_count;
  assign move_mag = move_abs[31] ? MAG_MAX : move_abs[STEP_W-1:0];

  logic              revs_neg;
  logic [15:0]       revs_abs;
  logic [PER_W-1:0]  per_turn;
  logic [PROD_W-1:0] revs_prod;
  logic [63:0]       revs_wide;
  logic [STEP_W-1:0] revs_mag;

  assign revs_neg  = cmd.revolutions[15];
  assign revs_abs  = revs_neg ? (~cmd.revolutions + 16'd1) : cmd.revolutions;
  assign per_turn  = half_step_mode ? PER_W'(STEPS_PER_TURN_HALF)
                                    : PER_W'(STEPS_PER_TURN_WAVE);
  assign revs_prod = PROD_W'(revs_abs) * PROD_W'(per_turn);
  assign revs_wide = 64'(revs_prod);
  assign revs_mag  = (|revs_wide[63:STEP_W]) ? MAG_MAX : revs_wide[STEP_W-1:0];

  // ---------------------------------------------------------------------------
  // next coil pattern: table position is the issued count modulo the table
  // length, mirrored when running in reverse
  // ---------------------------------------------------------------------------
  logic [2:0] half_idx;
  logic [1:0] wave_idx;
  logic [3:0] next_pattern;

  assign half_idx     = forward ? steps_issued[2:0] : ~steps_issued[2:0];
  assign wave_idx     = forward ? steps_issued[1:0] : ~steps_issued[1:0];
  assign next_pattern = half_step_mode ? half_pattern(half_idx) : wave_pattern(wave_idx);

  // ---------------------------------------------------------------------------
  // state update for one command word
  // ---------------------------------------------------------------------------
  logic [PERIOD_W-1:0] tick_count;
  logic                expired;

  assign tick_count = period_count + PERIOD_W'(1);
  // a zero period expires on every tick, same as a period of one
  assign expired    = tick_count >= step_period_us;

  always_comb begin
    steps_issued_next  = steps_issued;
    target_steps_next  = target_steps;
    forward_next       = forward;
    armed_next         = armed;
    period_count_next  = period_count;
    coil_register_next = coil_register;
    case (cmd.command)
      CMD_TICK: begin
        if (armed) begin
          period_count_next = tick_count;
          if (expired) begin
            period_count_next = '0;
            if (steps_issued < target_steps) begin
              coil_register_next = next_pattern;
              steps_issued_next  = steps_issued + STEP_W'(1);
            end else begin
              // move finished: coils off, timer stops
              coil_register_next = '0;
              steps_issued_next  = '0;
              target_steps_next  = '0;
              armed_next         = 1'b0;
            end
          end
        end
      end
      CMD_MOVE: begin
        forward_next      = !move_neg && (cmd.step_count != '0);
        target_steps_next = move_mag;
        steps_issued_next = '0;
        period_count_next = '0;
        armed_next        = 1'b1;
      end
      CMD_REVS: begin
        forward_next      = !revs_neg && (revs_mag != '0);
        target_steps_next = revs_mag;
        steps_issued_next = '0;
        period_count_next = '0;
        armed_next        = 1'b1;
      end
      default: ; // unused code: state unchanged, result still reported
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      steps_issued  <= '0;
      target_steps  <= '0;
      forward       <= 1'b0;
      armed         <= 1'b0;
      period_count  <= '0;
      coil_register <= '0;
    end else if (cmd_fire) begin
      steps_issued  <= steps_issued_next;
      target_steps  <= target_steps_next;
      forward       <= forward_next;
      armed         <= armed_next;
      period_count  <= period_count_next;
      coil_register <= coil_register_next;
    end
  end

  // ---------------------------------------------------------------------------
  // result register, loaded with the post-update state
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd_fire) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_fire) begin
      res_coil  <= coil_register_next;
      res_busy  <= armed_next;
      res_steps <= steps_issued_next;
    end
  end

  assign res.valid        = res_valid;
  assign res.coil_pattern = res_coil;
  assign res.busy_res     = res_busy;
  assign res.steps_done   = res_steps;

endmodule
